// File: sv/mrpt_pkg.sv
// Shared constants, types and the control program of the Miller-Rabin prime test.
// Used by the channel interfaces and by miller_rabin_prime_test; depends on nothing.
package mrpt_pkg;

   // Default sizes
   localparam int NUM_WIDTH_DEF  = 63;
   localparam int MAX_ROUNDS_DEF = 12;
   localparam int ROUNDS_W       = 4;
   localparam int WIT_COUNT      = 12;
   localparam int WIT_IDX_W      = $clog2(WIT_COUNT);
   localparam int WIT_W          = 6;

   // Fixed prime witnesses, tried from the start of the list
   localparam logic [WIT_W-1:0] WITNESS_TAB [WIT_COUNT] =
      '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

   // Datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
   localparam logic [OP_W-1:0] OP_SHR    = 4'd1;   // strip one factor of two from s
   localparam logic [OP_W-1:0] OP_WLOAD  = 4'd2;   // base <= witness
   localparam logic [OP_W-1:0] OP_WRED   = 4'd3;   // base <= base - n when base >= n
   localparam logic [OP_W-1:0] OP_PINIT  = 4'd4;   // e <= s, y <= 1
   localparam logic [OP_W-1:0] OP_MUL_YB = 4'd5;   // y <= y * base mod n
   localparam logic [OP_W-1:0] OP_MUL_BB = 4'd6;   // base <= base^2 mod n, e >>= 1
   localparam logic [OP_W-1:0] OP_MUL_YY = 4'd7;   // y <= y^2 mod n, q++
   localparam logic [OP_W-1:0] OP_QINIT  = 4'd8;   // q <= 1
   localparam logic [OP_W-1:0] OP_INC_I  = 4'd9;   // next witness
   localparam logic [OP_W-1:0] OP_PASS   = 4'd10;  // report prime
   localparam logic [OP_W-1:0] OP_FAIL   = 4'd11;  // report composite

   // Jump conditions
   localparam int CND_W = 4;
   localparam logic [CND_W-1:0] CND_NEVER  = 4'd0;
   localparam logic [CND_W-1:0] CND_ALWAYS = 4'd1;
   localparam logic [CND_W-1:0] CND_LT2    = 4'd2;
   localparam logic [CND_W-1:0] CND_EQ2    = 4'd3;
   localparam logic [CND_W-1:0] CND_EVEN   = 4'd4;
   localparam logic [CND_W-1:0] CND_S_EVEN = 4'd5;
   localparam logic [CND_W-1:0] CND_W_GE_N = 4'd6;
   localparam logic [CND_W-1:0] CND_W_ZERO = 4'd7;
   localparam logic [CND_W-1:0] CND_E_ZERO = 4'd8;
   localparam logic [CND_W-1:0] CND_E_EVEN = 4'd9;
   localparam logic [CND_W-1:0] CND_Y_ONE  = 4'd10;
   localparam logic [CND_W-1:0] CND_Y_NM1  = 4'd11;
   localparam logic [CND_W-1:0] CND_Q_GE_K = 4'd12;
   localparam logic [CND_W-1:0] CND_I_LAST = 4'd13;

   // Program labels
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_STRIP  = 5'd3;
   localparam logic [PC_W-1:0] PC_WLOAD  = 5'd4;
   localparam logic [PC_W-1:0] PC_WRED   = 5'd5;
   localparam logic [PC_W-1:0] PC_ELOOP  = 5'd8;
   localparam logic [PC_W-1:0] PC_SQBASE = 5'd11;
   localparam logic [PC_W-1:0] PC_YCHECK = 5'd12;
   localparam logic [PC_W-1:0] PC_QLOOP  = 5'd15;
   localparam logic [PC_W-1:0] PC_NEXTW  = 5'd20;
   localparam logic [PC_W-1:0] PC_PASS   = 5'd22;
   localparam logic [PC_W-1:0] PC_FAIL   = 5'd23;
   localparam logic [PC_W-1:0] PC_LAST   = 5'd23;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CND_W-1:0] cond;
      logic [PC_W-1:0]  target;
   } ucode_type;

   // Control store: one word per step, fall through to pc+1 unless the jump is taken
   function automatic ucode_type prog_rom(input logic [PC_W-1:0] pc);
      ucode_type uc;
      uc = '{op: OP_NOP, cond: CND_ALWAYS, target: PC_FAIL};
      unique case (pc)
         5'd0:  uc = '{op: OP_NOP,    cond: CND_LT2,    target: PC_FAIL};
         5'd1:  uc = '{op: OP_NOP,    cond: CND_EQ2,    target: PC_PASS};
         5'd2:  uc = '{op: OP_NOP,    cond: CND_EVEN,   target: PC_FAIL};
         5'd3:  uc = '{op: OP_SHR,    cond: CND_S_EVEN, target: PC_STRIP};
         5'd4:  uc = '{op: OP_WLOAD,  cond: CND_NEVER,  target: PC_WLOAD};
         5'd5:  uc = '{op: OP_WRED,   cond: CND_W_GE_N, target: PC_WRED};
         5'd6:  uc = '{op: OP_NOP,    cond: CND_W_ZERO, target: PC_NEXTW};
         5'd7:  uc = '{op: OP_PINIT,  cond: CND_NEVER,  target: PC_ELOOP};
         5'd8:  uc = '{op: OP_NOP,    cond: CND_E_ZERO, target: PC_YCHECK};
         5'd9:  uc = '{op: OP_NOP,    cond: CND_E_EVEN, target: PC_SQBASE};
         5'd10: uc = '{op: OP_MUL_YB, cond: CND_NEVER,  target: PC_SQBASE};
         5'd11: uc = '{op: OP_MUL_BB, cond: CND_ALWAYS, target: PC_ELOOP};
         5'd12: uc = '{op: OP_NOP,    cond: CND_Y_ONE,  target: PC_NEXTW};
         5'd13: uc = '{op: OP_NOP,    cond: CND_Y_NM1,  target: PC_NEXTW};
         5'd14: uc = '{op: OP_QINIT,  cond: CND_NEVER,  target: PC_QLOOP};
         5'd15: uc = '{op: OP_NOP,    cond: CND_Q_GE_K, target: PC_FAIL};
         5'd16: uc = '{op: OP_MUL_YY, cond: CND_NEVER,  target: PC_QLOOP};
         5'd17: uc = '{op: OP_NOP,    cond: CND_Y_NM1,  target: PC_NEXTW};
         5'd18: uc = '{op: OP_NOP,    cond: CND_Y_ONE,  target: PC_FAIL};
         5'd19: uc = '{op: OP_NOP,    cond: CND_ALWAYS, target: PC_QLOOP};
         5'd20: uc = '{op: OP_INC_I,  cond: CND_I_LAST, target: PC_PASS};
         5'd21: uc = '{op: OP_NOP,    cond: CND_ALWAYS, target: PC_WLOAD};
         5'd22: uc = '{op: OP_PASS,   cond: CND_NEVER,  target: PC_PASS};
         5'd23: uc = '{op: OP_FAIL,   cond: CND_NEVER,  target: PC_FAIL};
         default: uc = '{op: OP_FAIL, cond: CND_NEVER,  target: PC_FAIL};
      endcase
      return uc;
   endfunction

endpackage

// File: sv/mrpt_if.sv
// Valid/ready channel interfaces for the Miller-Rabin prime test.
// Depends on mrpt_pkg for the default operand width.
interface mrpt_req_if #(parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEF) ();
   logic                 valid;
   logic                 ready;
   logic [NUM_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_rsp_if ();
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

// File: sv/miller_rabin_prime_test.sv
// Miller-Rabin prime test, top level: microcoded sequencer over a shift-and-add
// modular multiplier. Depends on mrpt_pkg and the channel interfaces in mrpt_if.sv.
//
// Takes one candidate per request beat and returns one is_prime beat. The test
// runs one candidate at a time under a 24-step control program; the time is
// dominated by the single modular multiplier, which retires one multiplier bit
// per cycle between an operand load and a write-back. A witness costs about
// 2 * bits(s) multiplies for the power and up to k-1 squarings, so a full
// twelve-round test of a 63-bit prime needs about 12 * 126 multiplies; candidates
// below three and even candidates are settled by the first steps of the program.
// A new candidate is taken as soon as the previous result sits in the response
// register; that register holds the result until the response beat.
// csr_wr_data sets the number of witnesses (2, 3, 5, ... in order); zero reads
// as one and values above MAX_ROUNDS saturate. Write it only while idle.
module miller_rabin_prime_test #(
   parameter int MAX_ROUNDS = mrpt_pkg::MAX_ROUNDS_DEF,
   parameter int NUM_WIDTH  = mrpt_pkg::NUM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mrpt_req_if.sink                      req_chan,
   mrpt_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [mrpt_pkg::ROUNDS_W-1:0] csr_wr_data
);

   localparam int KW = $clog2(NUM_WIDTH);
   localparam int RW = mrpt_pkg::ROUNDS_W;
   localparam int IW = mrpt_pkg::WIT_IDX_W;

   // Control state
   logic                      busy_ff, busy_in;
   logic [mrpt_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                      mul_run_ff, mul_run_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]             rounds_ff, rounds_in;

   // Datapath
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] nm1_ff, nm1_in;
   logic [NUM_WIDTH-1:0] s_ff, s_in;
   logic [NUM_WIDTH-1:0] e_ff, e_in;
   logic [NUM_WIDTH-1:0] base_ff, base_in;
   logic [NUM_WIDTH-1:0] y_ff, y_in;
   logic [NUM_WIDTH-1:0] ma_ff, ma_in;
   logic [NUM_WIDTH-1:0] mb_ff, mb_in;
   logic [NUM_WIDTH-1:0] macc_ff, macc_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [KW-1:0]        q_ff, q_in;
   logic [IW-1:0]        i_ff, i_in;
   logic                 is_prime_ff, is_prime_in;

   mrpt_pkg::ucode_type uc;
   logic                mul_op;
   logic                mul_fin;
   logic                done_op;
   logic                hold;
   logic                cond_hit;
   logic [RW-1:0]       count;
   logic                accept;
   logic [NUM_WIDTH-1:0] one;

   // a + b mod m, with a, b < m
   function automatic logic [NUM_WIDTH-1:0] mod_add(input logic [NUM_WIDTH-1:0] a,
                                                    input logic [NUM_WIDTH-1:0] b,
                                                    input logic [NUM_WIDTH-1:0] m);
      logic [NUM_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
      return sum[NUM_WIDTH-1:0];
   endfunction

   assign one = {{(NUM_WIDTH-1){1'b0}}, 1'b1};

   // Effective witness count
   always_comb begin
      priority if (rounds_ff == '0) begin
         count = RW'(1);
      end else if (rounds_ff > RW'(MAX_ROUNDS)) begin
         count = RW'(MAX_ROUNDS);
      end else begin
         count = rounds_ff;
      end
   end

   assign uc      = mrpt_pkg::prog_rom(pc_ff);
   assign mul_op  = (uc.op == mrpt_pkg::OP_MUL_YB) || (uc.op == mrpt_pkg::OP_MUL_BB) ||
                    (uc.op == mrpt_pkg::OP_MUL_YY);
   assign mul_fin = mul_run_ff && (mb_ff == '0);
   assign done_op = (uc.op == mrpt_pkg::OP_PASS) || (uc.op == mrpt_pkg::OP_FAIL);
   assign hold    = (mul_op && !mul_fin) || (done_op && rsp_valid_ff && !rsp_chan.ready);

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_prime = is_prime_ff;

   // Jump condition select
   always_comb begin
      unique case (uc.cond)
         mrpt_pkg::CND_NEVER:  cond_hit = 1'b0;
         mrpt_pkg::CND_ALWAYS: cond_hit = 1'b1;
         mrpt_pkg::CND_LT2:    cond_hit = (n_ff[NUM_WIDTH-1:1] == '0);
         mrpt_pkg::CND_EQ2:    cond_hit = (n_ff == NUM_WIDTH'(2));
         mrpt_pkg::CND_EVEN:   cond_hit = !n_ff[0];
         mrpt_pkg::CND_S_EVEN: cond_hit = !s_ff[0];
         mrpt_pkg::CND_W_GE_N: cond_hit = (base_ff >= n_ff);
         mrpt_pkg::CND_W_ZERO: cond_hit = (base_ff == '0);
         mrpt_pkg::CND_E_ZERO: cond_hit = (e_ff == '0);
         mrpt_pkg::CND_E_EVEN: cond_hit = !e_ff[0];
         mrpt_pkg::CND_Y_ONE:  cond_hit = (y_ff == one);
         mrpt_pkg::CND_Y_NM1:  cond_hit = (y_ff == nm1_ff);
         mrpt_pkg::CND_Q_GE_K: cond_hit = (q_ff >= k_ff);
         mrpt_pkg::CND_I_LAST: cond_hit = ({1'b0, i_ff} + 5'd1) >= {1'b0, count};
         default:              cond_hit = 1'b0;
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      mul_run_in   = mul_run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rounds_in    = csr_wr_en ? csr_wr_data : rounds_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      base_in      = base_ff;
      y_in         = y_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      macc_in      = macc_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      i_in         = i_ff;
      is_prime_in  = is_prime_ff;

      if (accept) begin
         // load a new candidate and start the program
         n_in    = req_chan.candidate;
         nm1_in  = req_chan.candidate - one;
         s_in    = req_chan.candidate - one;
         k_in    = '0;
         i_in    = '0;
         pc_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         unique case (uc.op)
            mrpt_pkg::OP_NOP: begin
            end
            mrpt_pkg::OP_SHR: begin
               if (!s_ff[0]) begin
                  s_in = s_ff >> 1;
                  k_in = k_ff + KW'(1);
               end
            end
            mrpt_pkg::OP_WLOAD: begin
               base_in = NUM_WIDTH'(mrpt_pkg::WITNESS_TAB[i_ff]);
            end
            mrpt_pkg::OP_WRED: begin
               if (base_ff >= n_ff) begin
                  base_in = base_ff - n_ff;
               end
            end
            mrpt_pkg::OP_PINIT: begin
               e_in = s_ff;
               y_in = one;
            end
            mrpt_pkg::OP_MUL_YB, mrpt_pkg::OP_MUL_BB, mrpt_pkg::OP_MUL_YY: begin
               priority if (!mul_run_ff) begin
                  // load multiplier operands
                  ma_in      = (uc.op == mrpt_pkg::OP_MUL_BB) ? base_ff : y_ff;
                  mb_in      = (uc.op == mrpt_pkg::OP_MUL_YY) ? y_ff : base_ff;
                  macc_in    = '0;
                  mul_run_in = 1'b1;
               end else if (mul_fin) begin
                  // write back the product
                  mul_run_in = 1'b0;
                  if (uc.op == mrpt_pkg::OP_MUL_BB) begin
                     base_in = macc_ff;
                     e_in    = e_ff >> 1;
                  end else begin
                     y_in = macc_ff;
                  end
                  if (uc.op == mrpt_pkg::OP_MUL_YY) begin
                     q_in = q_ff + KW'(1);
                  end
               end else begin
                  // one shift-and-add step
                  if (mb_ff[0]) begin
                     macc_in = mod_add(macc_ff, ma_ff, n_ff);
                  end
                  ma_in = mod_add(ma_ff, ma_ff, n_ff);
                  mb_in = mb_ff >> 1;
               end
            end
            mrpt_pkg::OP_QINIT: begin
               q_in = KW'(1);
            end
            mrpt_pkg::OP_INC_I: begin
               i_in = i_ff + IW'(1);
            end
            mrpt_pkg::OP_PASS, mrpt_pkg::OP_FAIL: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_in = 1'b1;
                  is_prime_in  = (uc.op == mrpt_pkg::OP_PASS);
                  busy_in      = 1'b0;
               end
            end
            default: begin
            end
         endcase

         // advance the step counter
         if (!hold) begin
            pc_in = cond_hit ? uc.target : pc_ff + mrpt_pkg::PC_W'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         mul_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rounds_ff    <= RW'(12);
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         mul_run_ff   <= mul_run_in;
         rsp_valid_ff <= rsp_valid_in;
         rounds_ff    <= rounds_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      nm1_ff      <= nm1_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      base_ff     <= base_in;
      y_ff        <= y_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      macc_ff     <= macc_in;
      k_ff        <= k_in;
      q_ff        <= q_in;
      i_ff        <= i_in;
      is_prime_ff <= is_prime_in;
   end

   // The step counter never leaves the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= mrpt_pkg::PC_LAST))
      else $error("step counter outside the program");

   // The multiplier only runs under a multiply step
   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_run_ff |-> (busy_ff && mul_op))
      else $error("multiplier running outside a multiply step");

   // Multiplier operands stay reduced modulo the candidate
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_run_ff |-> ((ma_ff < n_ff) && (macc_ff < n_ff)))
      else $error("multiplier operand not reduced");

   // A finishing step with a free output register posts a response beat
   a_post: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && done_op && !(rsp_valid_ff && !rsp_chan.ready)) |=> (rsp_valid_ff && !busy_ff))
      else $error("finished test did not post a response");

   // An accepted beat starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (pc_ff == '0) && !mul_run_ff))
      else $error("accepted candidate did not start the program");

endmodule
